/* src/pqm_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and defaults for the process queue manager.
// No dependencies; pqm_ctrl and the top level refer to it by scoped names.
package pqm_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int NUM_QUEUES_DEF  = 4;
	localparam int ID_W            = 8;
	localparam int PRIO_W          = 4;
	localparam int MASK_W          = 4;
	localparam logic [MASK_W-1:0] MASK_RESET = 4'd10;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_DEQUEUE = 2'd1,
		ACT_REMOVE  = 2'd2,
		ACT_FIND    = 2'd3
	} action_t;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		action_t           action;
		logic [1:0]        queue_sel;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [1:0]        queue;
	} result_t;

endpackage

/* src/pqm_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pqm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/pqm_ctrl.sv */
`timescale 1ns / 1ps
// Command sequencer: sweeps queue cells in the entry RAM, shifts on insert, dequeue and remove.
// Depends on pqm_pkg; drives the entry RAM ports of the top level.
module pqm_ctrl #(
	parameter int QUEUE_DEPTH = pqm_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_QUEUES  = pqm_pkg::NUM_QUEUES_DEF,
	localparam int AW = (NUM_QUEUES * QUEUE_DEPTH > 1) ? $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  pqm_pkg::cmd_t               cmd,
	input  logic [pqm_pkg::MASK_W-1:0]  mask,
	output logic                        idle,
	output logic                        res_valid,
	output pqm_pkg::result_t            res,
	input  logic                        res_take,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  pqm_pkg::entry_t             mem_rdata,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output pqm_pkg::entry_t             mem_wdata
);

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QW-1:0] LAST_Q   = QW'(NUM_QUEUES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	pqm_pkg::ctrl_state_t state_q, state_d;
	pqm_pkg::cmd_t        cmd_q;
	pqm_pkg::entry_t      carry_q, hit_q;
	pqm_pkg::result_t     res_q, res_d;
	logic [QW-1:0]        cur_q_q;
	logic                 bad_sel_q;
	logic [CW-1:0]        limit_q, rd_idx_q, idx_s1;
	logic                 pend_s1;
	logic                 found_q;
	logic [CW-1:0]        counts_q [NUM_QUEUES];

	logic [CW-1:0]        n;
	logic [AW-1:0]        base;
	logic                 is_insert, ordered, issue, hit, shift, fin, fin_next;
	pqm_pkg::entry_t      new_entry;

	assign is_insert = (cmd_q.action == pqm_pkg::ACT_INSERT);
	assign ordered   = mask[cmd_q.queue_sel];
	assign n         = ({1'b0, cur_q_q} < (QW+1)'(NUM_QUEUES)) ? counts_q[cur_q_q] : '0;
	assign base      = AW'(cur_q_q) * AW'(QUEUE_DEPTH);
	assign issue     = (state_q == pqm_pkg::S_SCAN) && (rd_idx_q < limit_q);
	assign new_entry = '{id: cmd_q.id, prio: cmd_q.prio};

	assign mem_re    = issue;
	assign mem_raddr = base + AW'(rd_idx_q);
	assign idle      = (state_q == pqm_pkg::S_IDLE);
	assign res_valid = (state_q == pqm_pkg::S_FINISH);
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = base + AW'(idx_s1);
		mem_wdata = new_entry;
		hit       = 1'b0;
		shift     = 1'b0;
		fin       = 1'b0;
		fin_next  = 1'b0;
		unique case (state_q)
			pqm_pkg::S_IDLE: begin
				if (start) begin
					state_d = pqm_pkg::S_CHECK;
				end
			end
			pqm_pkg::S_CHECK: begin
				if (bad_sel_q || (is_insert && n >= FULL_CNT)) begin
					state_d = pqm_pkg::S_FINISH;
					res_d   = '{status: is_insert ? pqm_pkg::STAT_FULL : pqm_pkg::STAT_MISS,
						id: '0, prio: '0, queue: cmd_q.queue_sel};
				end else begin
					state_d = pqm_pkg::S_SCAN;
				end
			end
			pqm_pkg::S_SCAN: begin
				if (pend_s1) begin
					unique case (cmd_q.action)
						pqm_pkg::ACT_INSERT: begin
							if (!found_q && mem_rdata.prio > cmd_q.prio) begin
								hit    = 1'b1;
								mem_we = 1'b1;
							end else if (found_q) begin
								shift     = 1'b1;
								mem_we    = 1'b1;
								mem_wdata = carry_q;
							end
						end
						pqm_pkg::ACT_DEQUEUE, pqm_pkg::ACT_REMOVE: begin
							if (!found_q && (cmd_q.action == pqm_pkg::ACT_DEQUEUE
								|| mem_rdata.id == cmd_q.id)) begin
								hit = 1'b1;
							end else if (found_q) begin
								mem_we    = 1'b1;
								mem_waddr = base + AW'(idx_s1 - CW'(1));
								mem_wdata = mem_rdata;
							end
						end
						pqm_pkg::ACT_FIND: begin
							if (mem_rdata.id == cmd_q.id) begin
								hit     = 1'b1;
								state_d = pqm_pkg::S_FINISH;
								res_d   = '{status: pqm_pkg::STAT_OK, id: mem_rdata.id,
									prio: mem_rdata.prio, queue: 2'(cur_q_q)};
							end
						end
					endcase
				end else if (!issue) begin
					unique case (cmd_q.action)
						pqm_pkg::ACT_INSERT: begin
							fin       = 1'b1;
							state_d   = pqm_pkg::S_FINISH;
							mem_we    = 1'b1;
							mem_waddr = base + AW'(n);
							mem_wdata = found_q ? carry_q : new_entry;
							res_d     = '{status: pqm_pkg::STAT_OK, id: '0, prio: '0,
								queue: cmd_q.queue_sel};
						end
						pqm_pkg::ACT_DEQUEUE, pqm_pkg::ACT_REMOVE: begin
							fin     = 1'b1;
							state_d = pqm_pkg::S_FINISH;
							if (found_q) begin
								res_d = '{status: pqm_pkg::STAT_OK, id: hit_q.id,
									prio: hit_q.prio, queue: cmd_q.queue_sel};
							end else begin
								res_d = '{status: pqm_pkg::STAT_MISS, id: '0, prio: '0,
									queue: cmd_q.queue_sel};
							end
						end
						pqm_pkg::ACT_FIND: begin
							if (cur_q_q == LAST_Q) begin
								state_d = pqm_pkg::S_FINISH;
								res_d   = '{status: pqm_pkg::STAT_MISS, id: '0, prio: '0,
									queue: '0};
							end else begin
								fin_next = 1'b1;
								state_d  = pqm_pkg::S_CHECK;
							end
						end
					endcase
				end
			end
			pqm_pkg::S_FINISH: begin
				if (res_take) begin
					state_d = pqm_pkg::S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqm_pkg::S_IDLE;
			pend_s1 <= 1'b0;
			found_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			pend_s1 <= issue && (state_d == pqm_pkg::S_SCAN);
			if (state_q == pqm_pkg::S_CHECK) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			if (fin && is_insert) begin
				counts_q[cur_q_q] <= n + CW'(1);
			end else if (fin && found_q) begin
				counts_q[cur_q_q] <= n - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		idx_s1 <= rd_idx_q;
		if (start && state_q == pqm_pkg::S_IDLE) begin
			cmd_q     <= cmd;
			cur_q_q   <= (cmd.action == pqm_pkg::ACT_FIND) ? '0 : QW'(cmd.queue_sel);
			bad_sel_q <= (cmd.action != pqm_pkg::ACT_FIND)
				&& (32'(cmd.queue_sel) >= NUM_QUEUES);
		end else if (fin_next) begin
			cur_q_q <= cur_q_q + QW'(1);
		end
		if (state_q == pqm_pkg::S_CHECK) begin
			rd_idx_q <= '0;
			limit_q  <= (is_insert && !ordered) ? '0 : n;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
		if (hit || shift) begin
			carry_q <= mem_rdata;
		end
		if (hit) begin
			hit_q <= mem_rdata;
		end
	end

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("entry RAM written and read at the same cell");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pqm_pkg::S_IDLE) |-> (n <= FULL_CNT))
		else $error("queue count above depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pqm_pkg::S_SCAN) |-> (rd_idx_q <= limit_q))
		else $error("read index past scan limit");

	a_no_stale_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pqm_pkg::S_SCAN) |-> !pend_s1)
		else $error("RAM read in flight outside scan");

	a_finish_after_check_or_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == pqm_pkg::S_FINISH) |->
		($past(state_q) == pqm_pkg::S_CHECK || $past(state_q) == pqm_pkg::S_SCAN))
		else $error("result produced without a scan");

endmodule

/* src/process_queue_manager.sv */
`timescale 1ns / 1ps
// Process queue manager: insert, dequeue, remove and find over several queues held in one RAM.
// Each command passes a check of the selected queue, then a scan with one RAM read per cycle;
// an insert into a full queue or a bad queue select skips the scan, a FIFO insert reads nothing,
// and a find checks and scans each queue in turn until it hits or the last queue is done.
// Throughput: one command in flight; a result held by m_tready low delays the next accept.
// Reset clears queue counts and restores the ordered-queue mask; RAM contents are not cleared.
module process_queue_manager #(
	parameter int QUEUE_DEPTH = pqm_pkg::QUEUE_DEPTH_DEF,
	parameter int NUM_QUEUES  = pqm_pkg::NUM_QUEUES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // action[1:0], queue_sel[3:2], proc_id[11:4], proc_priority[15:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[1:0], out_id[9:2], out_priority[13:10], out_queue[15:14]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // ordered_queue_mask
);

	localparam int CELLS = NUM_QUEUES * QUEUE_DEPTH;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

	logic [pqm_pkg::MASK_W-1:0] mask_q;
	logic                       m_tvalid_q;
	pqm_pkg::result_t           out_q;
	pqm_pkg::cmd_t              cmd;
	pqm_pkg::result_t           res;
	pqm_pkg::entry_t            mem_rdata, mem_wdata;
	logic                       idle, res_valid, out_free;
	logic                       mem_re, mem_we;
	logic [AW-1:0]              mem_raddr, mem_waddr;

	assign cmd = '{action: pqm_pkg::action_t'(s_tdata[1:0]), queue_sel: s_tdata[3:2],
		id: s_tdata[11:4], prio: s_tdata[15:12]};

	assign s_tready  = idle;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {out_q.queue, out_q.prio, out_q.id, out_q.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q     <= pqm_pkg::MASK_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mask_q <= cfg_data;
			end
			if (res_valid && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			out_q <= res;
		end
	end

	pqm_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.NUM_QUEUES (NUM_QUEUES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid),
		.cmd      (cmd),
		.mask     (mask_q),
		.idle     (idle),
		.res_valid(res_valid),
		.res      (res),
		.res_take (out_free),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata)
	);

	pqm_ram #(
		.WIDTH($bits(pqm_pkg::entry_t)),
		.DEPTH(CELLS)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
